### rtl/utf8hx_pkg.sv
package utf8hx_pkg;

   // Field widths of the channels.
   localparam int BYTE_W   = 8;
   localparam int HEX_W    = 7;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 11;
   localparam int CODE_W   = 16;

   // Reset value of the capacity register and default build-time ceiling.
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd512;
   localparam int CAPACITY_LIMIT_DEFAULT       = 1024;

   // Depth of the job queue between decoder and serialiser (a power of two).
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SEQ  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

   // Job kinds handed from the decoder to the serialiser.
   localparam logic [1:0] JOB_CODE = 2'd0;
   localparam logic [1:0] JOB_DONE = 2'd1;
   localparam logic [1:0] JOB_ERR  = 2'd2;

   typedef struct packed {
      logic [1:0]          kind;
      logic [STATUS_W-1:0] status;
      logic [CODE_W-1:0]   code;
   } job_type;

   typedef struct packed {
      logic [HEX_W-1:0]    hex_char;
      logic                char_valid;
      logic [STATUS_W-1:0] status;
      logic                done_res;
      logic                run_last;
   } result_type;

   // Upper-case ASCII hex digit of one nibble.
   function automatic logic [HEX_W-1:0] hex_digit(input logic [3:0] nib);
      logic [HEX_W-1:0] d;
      if (nib < 4'd10) begin
         d = 7'h30 + {3'd0, nib};
      end else begin
         d = 7'h41 + {3'd0, nib} - 7'd10;
      end
      return d;
   endfunction

endpackage

### rtl/utf8hx_front.sv
module utf8hx_front #(
   parameter int CAPACITY_LIMIT = utf8hx_pkg::CAPACITY_LIMIT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [utf8hx_pkg::BYTE_W-1:0] in_byte,
   input  logic [utf8hx_pkg::CAP_W-1:0]  capacity,
   output logic                          job_push,
   output utf8hx_pkg::job_type           job
);

   localparam int CNT_W = $clog2(CAPACITY_LIMIT + 1);
   localparam int CMP_W = ((CNT_W > utf8hx_pkg::CAP_W) ? CNT_W : utf8hx_pkg::CAP_W) + 1;

   logic [CNT_W-1:0]               chars_written_ff, chars_written_in;
   logic [utf8hx_pkg::CODE_W-1:0]  partial_code_ff, partial_code_in;
   logic [1:0]                     bytes_pending_ff, bytes_pending_in;
   logic                           discarding_ff, discarding_in;

   logic [CMP_W-1:0]               cap_eff;
   logic                           overflow;
   logic [utf8hx_pkg::CODE_W-1:0]  shifted;
   logic [utf8hx_pkg::CODE_W-1:0]  code;
   logic                           complete;

   // The effective capacity is the register clamped to the build ceiling.
   always_comb begin
      if (CMP_W'(capacity) > CMP_W'(CAPACITY_LIMIT)) begin
         cap_eff = CMP_W'(CAPACITY_LIMIT);
      end else begin
         cap_eff = CMP_W'(capacity);
      end
   end

   assign overflow = (CMP_W'(chars_written_ff) + CMP_W'(4)) >= cap_eff;
   assign shifted  = {partial_code_ff[utf8hx_pkg::CODE_W-7:0], in_byte[5:0]};

   always_comb begin
      chars_written_in = chars_written_ff;
      partial_code_in  = partial_code_ff;
      bytes_pending_in = bytes_pending_ff;
      discarding_in    = discarding_ff;
      job_push         = 1'b0;
      job.kind         = utf8hx_pkg::JOB_CODE;
      job.status       = utf8hx_pkg::ST_OK;
      job.code         = '0;
      complete         = 1'b0;
      code             = {{(utf8hx_pkg::CODE_W-utf8hx_pkg::BYTE_W){1'b0}}, in_byte};

      if (accept) begin
         if (discarding_ff) begin
            if (in_byte == '0) begin
               chars_written_in = '0;
               partial_code_in  = '0;
               bytes_pending_in = '0;
               discarding_in    = 1'b0;
            end
         end else if (in_byte == '0) begin
            job_push = 1'b1;
            if (bytes_pending_ff != 2'd0) begin
               job.kind   = utf8hx_pkg::JOB_ERR;
               job.status = utf8hx_pkg::ST_BAD_SEQ;
            end else begin
               job.kind   = utf8hx_pkg::JOB_DONE;
            end
            chars_written_in = '0;
            partial_code_in  = '0;
            bytes_pending_in = '0;
         end else if (bytes_pending_ff != 2'd0) begin
            partial_code_in  = shifted;
            bytes_pending_in = bytes_pending_ff - 2'd1;
            code             = shifted;
            complete         = (bytes_pending_ff == 2'd1);
         end else if (!in_byte[7]) begin
            complete = 1'b1;
         end else if (in_byte[7:5] == 3'b110) begin
            partial_code_in  = {11'd0, in_byte[4:0]};
            bytes_pending_in = 2'd1;
         end else if (in_byte[7:4] == 4'b1110) begin
            partial_code_in  = {12'd0, in_byte[3:0]};
            bytes_pending_in = 2'd2;
         end else begin
            job_push        = 1'b1;
            job.kind        = utf8hx_pkg::JOB_ERR;
            job.status      = utf8hx_pkg::ST_BAD_SEQ;
            discarding_in   = 1'b1;
            partial_code_in = '0;
         end

         // A finished code point either fits or aborts the string.
         if (complete) begin
            job_push = 1'b1;
            if (overflow) begin
               job.kind         = utf8hx_pkg::JOB_ERR;
               job.status       = utf8hx_pkg::ST_OVERFLOW;
               discarding_in    = 1'b1;
               bytes_pending_in = '0;
               partial_code_in  = '0;
            end else begin
               job.kind         = utf8hx_pkg::JOB_CODE;
               job.code         = code;
               chars_written_in = chars_written_ff + CNT_W'(4);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_written_ff <= '0;
         partial_code_ff  <= '0;
         bytes_pending_ff <= '0;
         discarding_ff    <= 1'b0;
      end else begin
         chars_written_ff <= chars_written_in;
         partial_code_ff  <= partial_code_in;
         bytes_pending_ff <= bytes_pending_in;
         discarding_ff    <= discarding_in;
      end
   end

   // While discarding, no sequence is in progress.
   a_discard_no_pending: assert property (@(posedge clock) disable iff (reset)
      discarding_ff |-> (bytes_pending_ff == 2'd0))
      else $error("sequence pending while discarding");

   // The character count stays below the build-time capacity ceiling.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(chars_written_ff) < CMP_W'(CAPACITY_LIMIT))
      else $error("character count beyond capacity ceiling");

endmodule

### rtl/utf8hx_queue.sv
module utf8hx_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  utf8hx_pkg::job_type push_data,
   input  logic                pop,
   output utf8hx_pkg::job_type pop_data,
   output logic                full,
   output logic                empty
);

   utf8hx_pkg::job_type                  slots_ff [utf8hx_pkg::QUEUE_DEPTH];
   logic [utf8hx_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [utf8hx_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [utf8hx_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                                 do_push, do_pop;

   assign full     = (count_ff == utf8hx_pkg::QCNT_W'(utf8hx_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= utf8hx_pkg::QCNT_W'(utf8hx_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != utf8hx_pkg::QCNT_W'(utf8hx_pkg::QUEUE_DEPTH)) |->
      (utf8hx_pkg::QPTR_W'(count_ff) == utf8hx_pkg::QPTR_W'(wr_ptr_ff - rd_ptr_ff)))
      else $error("queue pointers disagree with count");

endmodule

### rtl/utf8hx_back.sv
module utf8hx_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  utf8hx_pkg::job_type    q_data,
   output logic                   q_pop,
   input  logic                   rsp_pop,
   output logic                   rsp_valid,
   output utf8hx_pkg::result_type rsp
);

   logic                   cur_valid_ff, cur_valid_in;
   utf8hx_pkg::job_type    cur_job_ff, cur_job_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   out_valid_ff, out_valid_in;
   utf8hx_pkg::result_type out_ff, out_in;

   utf8hx_pkg::result_type item;
   logic [3:0]             nib;
   logic                   out_free, advance, cur_last, cur_done;

   always_comb begin
      case (idx_ff)
         2'd0:    nib = cur_job_ff.code[15:12];
         2'd1:    nib = cur_job_ff.code[11:8];
         2'd2:    nib = cur_job_ff.code[7:4];
         default: nib = cur_job_ff.code[3:0];
      endcase
   end

   always_comb begin
      item.hex_char   = '0;
      item.char_valid = 1'b0;
      item.status     = utf8hx_pkg::ST_OK;
      item.done_res   = 1'b1;
      item.run_last   = 1'b1;
      case (cur_job_ff.kind)
         utf8hx_pkg::JOB_CODE: begin
            item.hex_char   = utf8hx_pkg::hex_digit(nib);
            item.char_valid = 1'b1;
            item.done_res   = 1'b0;
            item.run_last   = (idx_ff == 2'd3);
         end
         utf8hx_pkg::JOB_ERR: begin
            item.status = cur_job_ff.status;
         end
         default: begin
            item.status = utf8hx_pkg::ST_OK;
         end
      endcase
   end

   assign out_free = !out_valid_ff || rsp_pop;
   assign advance  = cur_valid_ff && out_free;
   assign cur_last = (cur_job_ff.kind != utf8hx_pkg::JOB_CODE) || (idx_ff == 2'd3);
   assign cur_done = !cur_valid_ff || (advance && cur_last);
   assign q_pop    = cur_done && !q_empty;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_job_in   = cur_job_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_job_in   = q_data;
         idx_in       = 2'd0;
      end else if (cur_done) begin
         cur_valid_in = 1'b0;
      end else if (advance) begin
         idx_in = idx_ff + 2'd1;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = item;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_job_ff <= cur_job_in;
      out_ff     <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // Only a code job walks through its digits.
   a_idx_code_only: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && (cur_job_ff.kind != utf8hx_pkg::JOB_CODE)) |-> (idx_ff == 2'd0))
      else $error("digit index moved on a non-code job");

   // A character item is never a done item and always carries ok status.
   a_char_shape: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.char_valid) |->
      (!out_ff.done_res && (out_ff.status == utf8hx_pkg::ST_OK)))
      else $error("character item flagged as done or error");

   // Digits of one code point leave in order without gaps.
   a_digit_step: assert property (@(posedge clock) disable iff (reset)
      (advance && !cur_last) |=> (cur_valid_ff && (idx_ff == $past(idx_ff) + 2'd1)))
      else $error("digit index did not step");

endmodule

### rtl/utf8_to_ucs2_hex_encoder_top.sv
// UTF-8 to UCS-2 hex encoder.
// Bytes of a UTF-8 string enter on the request queue (push/full, req_in_byte);
// a zero byte ends the string. Each decoded code point of one to three bytes
// leaves as four upper-case ASCII hex digits, most significant first, on the
// result queue (empty/pop and the rsp_ fields). A clean end of string gives one
// done item; a bad lead byte, a sequence cut short, or output beyond the
// configured capacity gives one error item, after which bytes are dropped up
// to the terminator. The capacity register is written through csr_valid/
// csr_ready and csr_out_capacity, which is always ready; write it only idle.
// A byte is accepted in any cycle in which the four-entry job queue has room.
// The first item of a byte passes through the job queue, the current-job
// register and the output register. The serialiser delivers one item per
// cycle while jobs wait and the receiver pops; each code point gives four
// items, so ASCII streams are paced by it and multi-byte sequences cost less.
// When the receiver stalls, the output register holds its item, the queue
// fills and full rises. Reset clears the queue, the decoder state and sets the
// capacity to 512.
module utf8_to_ucs2_hex_encoder_top #(
   parameter int CAPACITY_LIMIT = utf8hx_pkg::CAPACITY_LIMIT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request side: one UTF-8 byte per item.
   input  logic                             push,
   output logic                             full,
   input  logic [utf8hx_pkg::BYTE_W-1:0]    req_in_byte,
   // Result side: one hex digit, done or error item each.
   output logic                             empty,
   input  logic                             pop,
   output logic [utf8hx_pkg::HEX_W-1:0]     rsp_hex_char,
   output logic                             rsp_char_valid,
   output logic [utf8hx_pkg::STATUS_W-1:0]  rsp_status,
   output logic                             rsp_done_res,
   output logic                             rsp_run_last,
   // Capacity register write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [utf8hx_pkg::CAP_W-1:0]     csr_out_capacity
);

   logic [utf8hx_pkg::CAP_W-1:0] out_capacity_ff, out_capacity_in;

   logic                   accept;
   logic                   job_push;
   utf8hx_pkg::job_type    job;
   logic                   q_full, q_empty, q_pop;
   utf8hx_pkg::job_type    q_data;
   logic                   rsp_valid;
   utf8hx_pkg::result_type rsp;

   // The capacity register takes any write; the user must write it only between strings.
   assign csr_ready       = 1'b1;
   assign out_capacity_in = (csr_valid && csr_ready) ? csr_out_capacity : out_capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_capacity_ff <= utf8hx_pkg::CAPACITY_RESET;
      end else begin
         out_capacity_ff <= out_capacity_in;
      end
   end

   // Every accepted byte may leave one job, so room in the queue gates intake.
   assign full   = q_full;
   assign accept = push && !q_full;

   utf8hx_front #(
      .CAPACITY_LIMIT (CAPACITY_LIMIT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_in_byte),
      .capacity (out_capacity_ff),
      .job_push (job_push),
      .job      (job)
   );

   utf8hx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   utf8hx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign empty          = !rsp_valid;
   assign rsp_hex_char   = rsp.hex_char;
   assign rsp_char_valid = rsp.char_valid;
   assign rsp_status     = rsp.status;
   assign rsp_done_res   = rsp.done_res;
   assign rsp_run_last   = rsp.run_last;

   // Error and done items are always the last item of their byte.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_done_res) |-> (rsp_run_last && !rsp_char_valid))
      else $error("done item not marked last");

   // A job is only produced on the cycle a byte is taken.
   a_job_needs_accept: assert property (@(posedge clock) disable iff (reset)
      job_push |-> accept)
      else $error("job produced without an accepted byte");

   // A held capacity only changes through the write channel.
   a_capacity_write: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_valid) |-> $stable(out_capacity_ff))
      else $error("capacity changed without a write");

endmodule

### dv/tb_top.sv
// Scoreboard for the hex encoder. It decodes every accepted byte itself and
// keeps, in order, the items that the block owes on its result queue.
class ucs2_hex_scoreboard;
   utf8hx_pkg::result_type awaited_items[$];
   logic [10:0] capacity;
   int unsigned chars_out;
   logic [15:0] code_acc;
   logic [1:0]  cont_left;
   bit          dropping;
   int          taken;
   int          errors;

   function new();
      capacity = utf8hx_pkg::CAPACITY_RESET;
      taken    = 0;
      errors   = 0;
      clear_string();
   endfunction

   function void clear_string();
      chars_out = 0;
      code_acc  = '0;
      cont_left = '0;
      dropping  = 1'b0;
   endfunction

   function logic [6:0] ascii_hex(logic [3:0] nib);
      return (nib < 4'd10) ? 7'h30 + 7'(nib) : 7'h37 + 7'(nib);
   endfunction

   function void queue_item(logic [6:0] ch, logic valid, logic [1:0] status,
                            logic done, logic last);
      utf8hx_pkg::result_type item;
      item.hex_char   = ch;
      item.char_valid = valid;
      item.status     = status;
      item.done_res   = done;
      item.run_last   = last;
      awaited_items.push_back(item);
   endfunction

   // A completed code point either fits in the buffer as four digits or
   // aborts the string with an overflow error.
   function void emit_code(logic [15:0] code);
      int unsigned limit;
      limit = (capacity > utf8hx_pkg::CAPACITY_LIMIT_DEFAULT) ?
              utf8hx_pkg::CAPACITY_LIMIT_DEFAULT : capacity;
      if (chars_out + 4 >= limit) begin
         dropping  = 1'b1;
         cont_left = '0;
         code_acc  = '0;
         queue_item('0, 1'b0, utf8hx_pkg::ST_OVERFLOW, 1'b1, 1'b1);
      end else begin
         for (int i = 0; i < 4; i++) begin
            queue_item(ascii_hex(4'((code >> (12 - 4 * i)) & 16'hF)), 1'b1,
                       utf8hx_pkg::ST_OK, 1'b0, i == 3);
         end
         chars_out += 4;
      end
   endfunction

   function void decode_byte(logic [7:0] b);
      bit cut;
      if (dropping) begin
         if (b == 8'h00) clear_string();
         return;
      end
      taken++;
      if (b == 8'h00) begin
         cut = (cont_left != 0);
         clear_string();
         queue_item('0, 1'b0, cut ? utf8hx_pkg::ST_BAD_SEQ : utf8hx_pkg::ST_OK,
                    1'b1, 1'b1);
         return;
      end
      if (cont_left != 0) begin
         // Continuation bytes are taken as they come; only the low six bits count.
         code_acc  = {code_acc[9:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 0) emit_code(code_acc);
         return;
      end
      if (!b[7]) begin
         emit_code({8'h00, b});
      end else if (b[7:5] == 3'b110) begin
         code_acc  = {11'd0, b[4:0]};
         cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         code_acc  = {12'd0, b[3:0]};
         cont_left = 2'd2;
      end else begin
         dropping = 1'b1;
         code_acc = '0;
         queue_item('0, 1'b0, utf8hx_pkg::ST_BAD_SEQ, 1'b1, 1'b1);
      end
   endfunction

   task report(string msg);
      if (errors < 40) $display("MISMATCH: %s", msg);
      errors++;
   endtask

   task compare_item(utf8hx_pkg::result_type got);
      utf8hx_pkg::result_type want;
      if (awaited_items.size() == 0) begin
         report($sformatf("item with nothing awaited: char %h valid %b status %0d done %b last %b",
                          got.hex_char, got.char_valid, got.status, got.done_res,
                          got.run_last));
         return;
      end
      want = awaited_items.pop_front();
      if (got.hex_char !== want.hex_char)
         report($sformatf("hex_char got %h want %h", got.hex_char, want.hex_char));
      if (got.char_valid !== want.char_valid)
         report($sformatf("char_valid got %b want %b", got.char_valid, want.char_valid));
      if (got.status !== want.status)
         report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.done_res !== want.done_res)
         report($sformatf("done_res got %b want %b", got.done_res, want.done_res));
      if (got.run_last !== want.run_last)
         report($sformatf("run_last got %b want %b", got.run_last, want.run_last));
   endtask
endclass

module tb_top;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE       = 12;
   localparam int PHASE_ITEMS  = 25;
   localparam int LONG_SYMBOLS = 260;

   // Directed opening: an empty string, ASCII extremes, the two- and
   // three-byte extremes (continuation bits unchecked), bad lead bytes with
   // bytes dropped after them, and strings cut short inside a sequence.
   localparam logic [7:0] OPENING [27] = '{
      8'h00, 8'h41, 8'h01, 8'h7F,
      8'hC2, 8'h80, 8'hDF, 8'hBF,
      8'hE0, 8'h80, 8'h80, 8'hEF, 8'hFF, 8'hFF, 8'h00,
      8'hBF, 8'h41, 8'h00,
      8'hF0, 8'h00,
      8'hFF, 8'h00,
      8'hE2, 8'h82, 8'h00,
      8'hC3, 8'h00
   };

   // Capacities per phase; the zero, tiny and oversized values sit among them.
   localparam logic [10:0] CAP_PLAN [9] = '{
      11'd512, 11'd5, 11'd0, 11'd4, 11'd2047, 11'd13, 11'd1024, 11'd9, 11'd64
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_in_byte = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [6:0]  rsp_hex_char;
   logic        rsp_char_valid;
   logic [1:0]  rsp_status;
   logic        rsp_done_res;
   logic        rsp_run_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_out_capacity = '0;

   ucs2_hex_scoreboard digits = new();

   bit tx_gaps   = 1'b0;
   bit rx_stalls = 1'b0;
   int stall_left = 0;
   int cycle_count = 0;

   utf8_to_ucs2_hex_encoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_hex_char     (rsp_hex_char),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_status       (rsp_status),
      .rsp_done_res     (rsp_done_res),
      .rsp_run_last     (rsp_run_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_out_capacity (csr_out_capacity)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Both handshakes are sampled at the edge, before any driver update lands.
   always @(posedge clock) begin
      if (!reset && pop && !empty)
         digits.compare_item({rsp_hex_char, rsp_char_valid, rsp_status, rsp_done_res,
                              rsp_run_last});
      if (!reset && push && !full)
         digits.decode_byte(req_in_byte);
   end

   // The receiver pops every cycle unless it is in a stall.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         pop <= 1'b0;
      end else if (rx_stalls && $urandom_range(0, 99) < 35) begin
         stall_left <= gap_len();
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   task send_byte(input logic [7:0] b);
      int g;
      g = tx_gaps ? gap_len() : 0;
      if (g > 0) begin
         push <= 1'b0;
         repeat (g) @(posedge clock);
      end
      push <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // Holds the sender back until every awaited item has arrived, then lets
   // the block finish any byte that owes nothing.
   task hold_until_drained();
      push <= 1'b0;
      @(posedge clock);
      while (digits.awaited_items.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_capacity(input logic [10:0] value);
      hold_until_drained();
      csr_valid <= 1'b1;
      csr_out_capacity <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      digits.capacity = value;
   endtask

   function automatic logic [7:0] cont_byte();
      if ($urandom_range(0, 9) != 0) return 8'h80 | 8'($urandom_range(0, 63));
      return 8'($urandom_range(1, 255));
   endfunction

   // One symbol of a string: a well-formed code point of one to three bytes,
   // or, unless clean is set, a bad lead byte or a sequence left unfinished.
   task send_symbol(input bit clean, output bit cut);
      int r;
      cut = 1'b0;
      r = clean ? $urandom_range(0, 87) : $urandom_range(0, 99);
      if (r < 40) begin
         send_byte(8'($urandom_range(1, 127)));
      end else if (r < 65) begin
         send_byte(8'hC0 | 8'($urandom_range(0, 31)));
         send_byte(cont_byte());
      end else if (r < 88) begin
         send_byte(8'hE0 | 8'($urandom_range(0, 15)));
         send_byte(cont_byte());
         send_byte(cont_byte());
      end else if (r < 94) begin
         if ($urandom_range(0, 1) != 0) send_byte(8'h80 | 8'($urandom_range(0, 63)));
         else send_byte(8'hF0 | 8'($urandom_range(0, 15)));
      end else begin
         if ($urandom_range(0, 1) != 0) begin
            send_byte(8'hC0 | 8'($urandom_range(0, 31)));
         end else begin
            send_byte(8'hE0 | 8'($urandom_range(0, 15)));
            if ($urandom_range(0, 1) != 0) send_byte(cont_byte());
         end
         cut = 1'b1;
      end
   endtask

   task send_string(input int symbols, input bit clean);
      bit cut;
      for (int i = 0; i < symbols; i++) begin
         send_symbol(clean, cut);
         if (cut) break;
         if ($urandom_range(0, 199) == 0) hold_until_drained();
      end
      send_byte(8'h00);
   endtask

   initial begin
      int start;
      logic [10:0] cap;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING[i]) send_byte(OPENING[i]);

      for (int p = 0; p < 9; p++) begin
         cap = (p == 7) ? 11'($urandom_range(5, 1024)) : CAP_PLAN[p];
         write_capacity(cap);
         tx_gaps   = (p % 3) != 0;
         rx_stalls = (p % 3) == 1;
         start = digits.taken;
         // An oversized setting is clamped, so a long ASCII string overflows
         // at the build-time ceiling.
         if (cap == 11'd2047) begin
            for (int i = 0; i < LONG_SYMBOLS; i++) send_byte(8'($urandom_range(1, 127)));
            send_byte(8'h00);
         end
         while (digits.taken - start < PHASE_ITEMS)
            send_string(($urandom_range(0, 99) < 85) ? $urandom_range(0, 6)
                                                     : $urandom_range(7, 30), 1'b0);
      end

      hold_until_drained();
      repeat (20) @(posedge clock);
      if (digits.errors == 0) begin
         $display("utf8_to_ucs2_hex_encoder_top test passed");
      end else begin
         $display("utf8_to_ucs2_hex_encoder_top test failed");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("utf8_to_ucs2_hex_encoder_top test failed");
      $finish;
   end

endmodule

### filelist.f
rtl/utf8hx_pkg.sv
rtl/utf8hx_front.sv
rtl/utf8hx_queue.sv
rtl/utf8hx_back.sv
rtl/utf8_to_ucs2_hex_encoder_top.sv
dv/tb_top.sv
